@@ design/lih_pkg.sv @@
// Shared types and constants for the lux interpolation block with hysteresis.
// Holds the calibration ROM, register indexes, event codes and controller types.
// Depends on nothing.
`timescale 1ns / 1ps

package lih_pkg;

   localparam int ROM_POINTS = 28;
   localparam int ROM_IDX_W  = $clog2(ROM_POINTS);
   localparam int MV_W       = 12;
   localparam int LUX_W      = 10;
   localparam int OUT_LUX_W  = 11;
   localparam int PROD_W     = MV_W + LUX_W;
   localparam int DIV_CNT_W  = $clog2(PROD_W);
   localparam int CSR_IDX_W  = 8;

   localparam logic [MV_W-1:0] CAL_MV [ROM_POINTS] = '{
      12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd16,   12'd31,
      12'd47,   12'd108,  12'd186,  12'd265,  12'd389,  12'd482,  12'd622,
      12'd731,  12'd840,  12'd949,  12'd1088, 12'd1166, 12'd1274, 12'd1351,
      12'd1445, 12'd1507, 12'd1554, 12'd1615, 12'd1677, 12'd1709, 12'd1756
   };

   localparam logic [LUX_W-1:0] CAL_LUX [ROM_POINTS] = '{
      10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
      10'd0,   10'd0,   10'd1,   10'd2,   10'd3,   10'd5,   10'd9,
      10'd12,  10'd18,  10'd22,  10'd29,  10'd36,  10'd44,  10'd52,
      10'd65,  10'd72,  10'd88,  10'd101, 10'd118, 10'd133, 10'd159
   };

   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD  = 8'd1;

   localparam logic [LUX_W-1:0] HIGH_THRESHOLD_RESET = 10'd30;
   localparam logic [LUX_W-1:0] LOW_THRESHOLD_RESET  = 10'd10;

   localparam logic [OUT_LUX_W-1:0] NO_LUX = 11'h7FF;

   localparam logic [1:0] EVT_NONE         = 2'd0;
   localparam logic [1:0] EVT_SUFFICIENT   = 2'd1;
   localparam logic [1:0] EVT_INSUFFICIENT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic search;
      logic mul;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic seg_hit;
      logic seg_last;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ design/lih_ctrl.sv @@
// Controller state machine for the lux interpolation block.
// Sequences load, segment search, multiply, divide and result write.
// Depends on lih_pkg.
`timescale 1ns / 1ps

module lih_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lih_pkg::status_type status,
   output lih_pkg::cmd_type    cmd
);

   lih_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lih_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lih_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lih_pkg::ST_SEARCH;
            end
         end
         lih_pkg::ST_SEARCH: begin
            priority if (status.seg_hit) begin
               state_in = lih_pkg::ST_MUL;
            end else if (status.seg_last) begin
               state_in = lih_pkg::ST_FINISH;
            end else begin
               state_in = lih_pkg::ST_SEARCH;
            end
         end
         lih_pkg::ST_MUL: begin
            state_in = lih_pkg::ST_DIV;
         end
         lih_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = lih_pkg::ST_FINISH;
            end
         end
         lih_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = lih_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lih_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         lih_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         lih_pkg::ST_SEARCH: begin
            cmd.search = 1'b1;
         end
         lih_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         lih_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         lih_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ design/lih_datapath.sv @@
// Datapath for the lux interpolation block: table search, multiplier,
// restoring divider, hysteresis state, threshold registers and result register.
// Depends on lih_pkg.
`timescale 1ns / 1ps

module lih_datapath #(
   parameter int TABLE_POINTS = 28
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lih_pkg::cmd_type                       cmd,
   output lih_pkg::status_type                    status,
   input  logic [lih_pkg::MV_W-1:0]               req_voltage_mv,
   input  logic                                   csr_valid,
   input  logic [lih_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [lih_pkg::LUX_W-1:0]              csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lih_pkg::OUT_LUX_W-1:0]   rsp_lux,
   output logic                                   rsp_in_range,
   output logic [1:0]                             rsp_level_event,
   output logic                                   rsp_bright
);

   localparam int PTS   = (TABLE_POINTS > lih_pkg::ROM_POINTS) ?
                          lih_pkg::ROM_POINTS : TABLE_POINTS;
   localparam int IDX_W = (PTS > 2) ? $clog2(PTS) : 1;
   localparam int MV_W  = lih_pkg::MV_W;
   localparam int LUX_W = lih_pkg::LUX_W;
   localparam int PW    = lih_pkg::PROD_W;
   localparam int CW    = lih_pkg::DIV_CNT_W;
   localparam int OW    = lih_pkg::OUT_LUX_W;

   logic [MV_W-1:0]  voltage_ff, voltage_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             hit_ff, hit_in;
   logic [LUX_W-1:0] base_ff, base_in;
   logic [MV_W-1:0]  span_ff, span_in;
   logic [MV_W-1:0]  rem_ff, rem_in;
   logic [PW-1:0]    quo_ff, quo_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [LUX_W-1:0] high_ff, high_in;
   logic [LUX_W-1:0] low_ff, low_in;
   logic             bright_ff, bright_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]    rsp_lux_ff, rsp_lux_in;
   logic             rsp_in_range_ff, rsp_in_range_in;
   logic [1:0]       rsp_event_ff, rsp_event_in;
   logic             rsp_bright_ff, rsp_bright_in;

   logic [lih_pkg::ROM_IDX_W-1:0] idx_a, idx_b;
   logic [MV_W-1:0]               mv_a, mv_b;
   logic [LUX_W-1:0]              lux_a, lux_b;
   logic                          seg_hit;
   logic [MV_W:0]                 shifted;
   logic [MV_W+1:0]               trial;
   logic                          ge;
   logic [LUX_W-1:0]              lux_sum;
   logic signed [OW-1:0]          lux_val;
   logic signed [OW-1:0]          high_s, low_s;

   assign idx_a   = lih_pkg::ROM_IDX_W'(k_ff);
   assign idx_b   = idx_a + 1'b1;
   assign mv_a    = lih_pkg::CAL_MV[idx_a];
   assign mv_b    = lih_pkg::CAL_MV[idx_b];
   assign lux_a   = lih_pkg::CAL_LUX[idx_a];
   assign lux_b   = lih_pkg::CAL_LUX[idx_b];
   assign seg_hit = (voltage_ff >= mv_a) && (voltage_ff <= mv_b);

   assign shifted = {rem_ff, quo_ff[PW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, span_ff};
   assign ge      = ~trial[MV_W+1];

   assign lux_sum = (span_ff == '0) ? base_ff : base_ff + quo_ff[LUX_W-1:0];
   assign lux_val = hit_ff ? $signed({1'b0, lux_sum}) : $signed(lih_pkg::NO_LUX);
   assign high_s  = $signed({1'b0, high_ff});
   assign low_s   = $signed({1'b0, low_ff});

   assign status.seg_hit  = seg_hit;
   assign status.seg_last = (k_ff == IDX_W'(PTS - 2));
   assign status.div_done = (cnt_ff == CW'(PW - 1));
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      voltage_in = voltage_ff;
      k_in       = k_ff;
      hit_in     = hit_ff;
      base_in    = base_ff;
      span_in    = span_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      if (cmd.load) begin
         voltage_in = req_voltage_mv;
         k_in       = '0;
         hit_in     = 1'b0;
      end
      if (cmd.search) begin
         hit_in = seg_hit;
         if (!seg_hit && !status.seg_last) begin
            k_in = k_ff + 1'b1;
         end
      end
      if (cmd.mul) begin
         base_in = lux_a;
         span_in = mv_b - mv_a;
         quo_in  = PW'(voltage_ff - mv_a) * PW'(lux_b - lux_a);
         rem_in  = '0;
         cnt_in  = '0;
      end
      if (cmd.div_step) begin
         rem_in = ge ? trial[MV_W-1:0] : shifted[MV_W-1:0];
         quo_in = {quo_ff[PW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      high_in = high_ff;
      low_in  = low_ff;
      if (csr_valid) begin
         if (csr_index == lih_pkg::CSR_HIGH_THRESHOLD) begin
            high_in = csr_data;
         end
         if (csr_index == lih_pkg::CSR_LOW_THRESHOLD) begin
            low_in = csr_data;
         end
      end
   end

   always_comb begin
      bright_in       = bright_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_lux_in      = rsp_lux_ff;
      rsp_in_range_in = rsp_in_range_ff;
      rsp_event_in    = rsp_event_ff;
      rsp_bright_in   = rsp_bright_ff;
      if (cmd.finish) begin
         rsp_valid_in    = 1'b1;
         rsp_lux_in      = lux_val;
         rsp_in_range_in = hit_ff;
         rsp_event_in    = lih_pkg::EVT_NONE;
         priority if (!bright_ff && (lux_val >= high_s)) begin
            bright_in    = 1'b1;
            rsp_event_in = lih_pkg::EVT_SUFFICIENT;
         end else if (bright_ff && (lux_val < low_s)) begin
            bright_in    = 1'b0;
            rsp_event_in = lih_pkg::EVT_INSUFFICIENT;
         end else begin
            bright_in    = bright_ff;
            rsp_event_in = lih_pkg::EVT_NONE;
         end
         rsp_bright_in = bright_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff      <= lih_pkg::HIGH_THRESHOLD_RESET;
         low_ff       <= lih_pkg::LOW_THRESHOLD_RESET;
         bright_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         high_ff      <= high_in;
         low_ff       <= low_in;
         bright_ff    <= bright_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      voltage_ff      <= voltage_in;
      k_ff            <= k_in;
      hit_ff          <= hit_in;
      base_ff         <= base_in;
      span_ff         <= span_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      cnt_ff          <= cnt_in;
      rsp_lux_ff      <= rsp_lux_in;
      rsp_in_range_ff <= rsp_in_range_in;
      rsp_event_ff    <= rsp_event_in;
      rsp_bright_ff   <= rsp_bright_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lux         = $signed(rsp_lux_ff);
   assign rsp_in_range    = rsp_in_range_ff;
   assign rsp_level_event = rsp_event_ff;
   assign rsp_bright      = rsp_bright_ff;

endmodule

@@ design/lux_interpolation_hysteresis.sv @@
// Top level of the lux interpolation block with hysteresis.
// Instantiates lih_ctrl and lih_datapath; depends on lih_pkg.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         valid / stall      voltage_mv
//   rsp_      out        valid / stall      lux, in_range, level_event, bright
//   csr_      in         valid / ready      index, data (thresholds)
//
// One request at a time: a load, a search over the table segments (up to
// TABLE_POINTS - 1, and never more than the 28-point ROM allows), and for a hit a
// multiply plus 22 divider steps, then a write of the result register.
// The result register frees the datapath; a new result waits in ST_FINISH while the last one is held by rsp_stall.
// Synchronous reset restores the thresholds to 30 and 10 and the dark state.
`timescale 1ns / 1ps

module lux_interpolation_hysteresis #(
   parameter int TABLE_POINTS = 28
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lih_pkg::MV_W-1:0]             req_voltage_mv,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lih_pkg::OUT_LUX_W-1:0] rsp_lux,
   output logic                                 rsp_in_range,
   output logic [1:0]                           rsp_level_event,
   output logic                                 rsp_bright,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lih_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lih_pkg::LUX_W-1:0]            csr_data
);

   lih_pkg::cmd_type    cmd;
   lih_pkg::status_type status;

   assign csr_ready = 1'b1;

   lih_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lih_datapath #(
      .TABLE_POINTS (TABLE_POINTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_voltage_mv  (req_voltage_mv),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lux         (rsp_lux),
      .rsp_in_range    (rsp_in_range),
      .rsp_level_event (rsp_level_event),
      .rsp_bright      (rsp_bright)
   );

endmodule
